// File: hdl/cll_pkg.sv
// Shared types and constants for the circular linked list manager.
package cll_pkg;

	localparam int NODE_W = 8;
	localparam int CNT_W  = 9;
	localparam int ACT_W  = 3;
	localparam int STAT_W = 2;

	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH_FRONT = 3'd0,
		ACT_APPEND     = 3'd1,
		ACT_REMOVE     = 3'd2,
		ACT_POP        = 3'd3,
		ACT_TEST       = 3'd4,
		ACT_CLEAR      = 3'd5
	} act_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_LINKED  = 2'd1,
		STAT_MISSING = 2'd2
	} stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LINK,
		ST_WALK
	} state_t;

endpackage

// File: hdl/circular_linked_list_manager.sv
// Circular singly linked list manager: successor memory, linked flags, head/tail/count.
// Test, clear, errors and linking into an empty list finish in the accept cycle; other
// links pass through the LINK state, pop and remove through the WALK state, which takes
// one successor hop per cycle through the single read port of the successor memory and is
// bounded by list length. Requests are accepted only in the idle state.
// Reset clears linked flags, tail, head, count and all handshake state at once;
// successor memory contents are not reset and need no clearing pass.
module circular_linked_list_manager #(
	parameter int NODES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] node
	input  logic [2:0]  s_tuser,   // [2:0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] result_node, [8] is_member, [16:9] head_node, [24:17] tail_node,
	// [33:25] node_count, [34] is_empty, [39:35] zero
	output logic [39:0] m_tdata,
	output logic [1:0]  m_tuser    // [1:0] status
);

	localparam int FN = (NODES < 256) ? NODES : 256;
	localparam int FW = $clog2(FN);
	localparam logic [cll_pkg::CNT_W-1:0] FN_C = cll_pkg::CNT_W'(FN);

	cll_pkg::state_t state_q, state_d;
	cll_pkg::stat_t  st_q, st_d;
	logic                          pend_q, pend_d;
	logic [cll_pkg::NODE_W-1:0]    res_q, res_d;
	logic                          mbr_q, mbr_d;
	logic [cll_pkg::NODE_W-1:0]    head_q, head_d;
	logic [cll_pkg::NODE_W-1:0]    tail_q, tail_d;
	logic [cll_pkg::CNT_W-1:0]     cnt_q, cnt_d;
	logic [FN-1:0]                 flag_q, flag_d;
	logic                          front_q, front_d;
	logic [cll_pkg::NODE_W-1:0]    tgt_q, tgt_d;
	logic [cll_pkg::NODE_W-1:0]    cur_q, cur_d;
	logic [cll_pkg::NODE_W-1:0]    prev_q, prev_d;

	logic [cll_pkg::NODE_W-1:0]    next_link [FN];
	logic [cll_pkg::NODE_W-1:0]    rd_q;
	logic                          we;
	logic [FW-1:0]                 waddr;
	logic [FW-1:0]                 raddr;
	logic [cll_pkg::NODE_W-1:0]    wdata;

	logic                          m_tvalid_q;
	logic [39:0]                   m_tdata_q;
	logic [1:0]                    m_tuser_q;

	cll_pkg::act_t                 in_act;
	logic [cll_pkg::NODE_W-1:0]    in_node;
	logic                          in_ok;
	logic                          out_free;
	logic                          load;
	logic                          accept;
	logic                          empty;

	assign in_act   = cll_pkg::act_t'(s_tuser);
	assign in_node  = s_tdata;
	assign in_ok    = ({1'b0, in_node} < FN_C);
	assign out_free = !m_tvalid_q || m_tready;
	assign load     = (state_q == cll_pkg::ST_IDLE) && pend_q && out_free;
	assign s_tready = (state_q == cll_pkg::ST_IDLE) && (!pend_q || out_free);
	assign accept   = s_tvalid && s_tready;
	assign empty    = (cnt_q == '0);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	always_comb begin
		state_d = state_q;
		pend_d  = pend_q && !load;
		st_d    = st_q;
		res_d   = res_q;
		mbr_d   = mbr_q;
		head_d  = head_q;
		tail_d  = tail_q;
		cnt_d   = cnt_q;
		flag_d  = flag_q;
		front_d = front_q;
		tgt_d   = tgt_q;
		cur_d   = cur_q;
		prev_d  = prev_q;
		we      = 1'b0;
		waddr   = in_node[FW-1:0];
		wdata   = in_node;
		raddr   = head_q[FW-1:0];
		case (state_q)
			cll_pkg::ST_IDLE: begin
				if (accept) begin
					st_d   = cll_pkg::STAT_OK;
					res_d  = '0;
					mbr_d  = 1'b0;
					pend_d = 1'b1;
					case (in_act)
						cll_pkg::ACT_PUSH_FRONT, cll_pkg::ACT_APPEND: begin
							if (!in_ok) begin
								st_d = cll_pkg::STAT_MISSING;
							end else if (flag_q[in_node[FW-1:0]]) begin
								st_d = cll_pkg::STAT_LINKED;
							end else if (empty) begin
								we                     = 1'b1;
								flag_d[in_node[FW-1:0]] = 1'b1;
								head_d                 = in_node;
								tail_d                 = in_node;
								cnt_d                  = cnt_q + 1'b1;
							end else begin
								we                     = 1'b1;
								wdata                  = head_q;
								flag_d[in_node[FW-1:0]] = 1'b1;
								front_d                = (in_act == cll_pkg::ACT_PUSH_FRONT);
								tgt_d                  = in_node;
								pend_d                 = 1'b0;
								state_d                = cll_pkg::ST_LINK;
							end
						end
						cll_pkg::ACT_REMOVE: begin
							if (!in_ok || !flag_q[in_node[FW-1:0]]) begin
								st_d = cll_pkg::STAT_MISSING;
							end else begin
								tgt_d   = in_node;
								cur_d   = head_q;
								prev_d  = tail_q;
								pend_d  = 1'b0;
								state_d = cll_pkg::ST_WALK;
							end
						end
						cll_pkg::ACT_POP: begin
							if (empty) begin
								st_d = cll_pkg::STAT_MISSING;
							end else begin
								tgt_d   = head_q;
								cur_d   = head_q;
								prev_d  = tail_q;
								pend_d  = 1'b0;
								state_d = cll_pkg::ST_WALK;
							end
						end
						cll_pkg::ACT_TEST: begin
							mbr_d = in_ok && flag_q[in_node[FW-1:0]];
						end
						cll_pkg::ACT_CLEAR: begin
							flag_d = '0;
							tail_d = '0;
							cnt_d  = '0;
						end
						default: begin
						end
					endcase
				end
			end
			cll_pkg::ST_LINK: begin
				we      = 1'b1;
				waddr   = tail_q[FW-1:0];
				wdata   = tgt_q;
				cnt_d   = cnt_q + 1'b1;
				if (front_q) begin
					head_d = tgt_q;
				end else begin
					tail_d = tgt_q;
				end
				pend_d  = 1'b1;
				state_d = cll_pkg::ST_IDLE;
			end
			cll_pkg::ST_WALK: begin
				// rd_q holds the successor of cur_q
				raddr = rd_q[FW-1:0];
				if (cur_q == tgt_q) begin
					we                    = 1'b1;
					waddr                 = prev_q[FW-1:0];
					wdata                 = rd_q;
					flag_d[tgt_q[FW-1:0]] = 1'b0;
					cnt_d                 = cnt_q - 1'b1;
					if (tgt_q == head_q) begin
						head_d = rd_q;
					end
					if (tgt_q == tail_q) begin
						tail_d = (prev_q == tgt_q) ? '0 : prev_q;
					end
					res_d   = tgt_q;
					pend_d  = 1'b1;
					state_d = cll_pkg::ST_IDLE;
				end else if (cur_q == tail_q) begin
					st_d    = cll_pkg::STAT_MISSING;
					pend_d  = 1'b1;
					state_d = cll_pkg::ST_IDLE;
				end else begin
					prev_d = cur_q;
					cur_d  = rd_q;
				end
			end
			default: begin
				state_d = cll_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= cll_pkg::ST_IDLE;
			pend_q     <= 1'b0;
			head_q     <= '0;
			tail_q     <= '0;
			cnt_q      <= '0;
			flag_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			cnt_q   <= cnt_d;
			flag_q  <= flag_d;
			if (load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		st_q    <= st_d;
		res_q   <= res_d;
		mbr_q   <= mbr_d;
		front_q <= front_d;
		tgt_q   <= tgt_d;
		cur_q   <= cur_d;
		prev_q  <= prev_d;
		if (load) begin
			m_tuser_q <= st_q;
			m_tdata_q <= {5'd0, empty, cnt_q, tail_q, (empty ? 8'd0 : head_q), mbr_q, res_q};
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			next_link[waddr] <= wdata;
		end
		rd_q <= next_link[raddr];
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FN_C) else $error("node count beyond pool size");

	a_tail_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> tail_q == '0) else $error("tail not zero on empty list");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> state_q == cll_pkg::ST_IDLE) else $error("ready outside idle");

	a_link_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cll_pkg::ST_LINK |=> state_q == cll_pkg::ST_IDLE && pend_q)
		else $error("link did not complete");

	a_accept_tracked: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> pend_q || state_q != cll_pkg::ST_IDLE)
		else $error("accepted request lost");

endmodule
